// File: rtl/lpbc_pkg.sv
// ----------------------------------------------------------------------------
// lpbc_pkg
// Shared types, codes and the byte-to-rank table of the compressor.
// ----------------------------------------------------------------------------
package lpbc_pkg;

    // item kinds
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // header and code layout
    localparam int HDR_LAST_IDX = 3;
    localparam int LEN_FIELD_W  = 3;
    localparam int RES_W        = 7;
    localparam int RES_CNT_W    = 3;
    localparam int ACC_W        = 18;
    localparam int ALIGN_W      = 24;
    localparam int TOTAL_W      = 5;

    typedef logic [7:0] rom_t [256];

    // fixed permutation: rank -> byte
    localparam rom_t PERM_ROM = '{
        8'h00, 8'hFF, 8'h89, 8'h8B, 8'h04, 8'h83, 8'hE8, 8'h75,
        8'h66, 8'h08, 8'h05, 8'h74, 8'h0F, 8'h01, 8'h45, 8'h20,
        8'h10, 8'h55, 8'h0C, 8'hC7, 8'hC0, 8'hEB, 8'h85, 8'h65,
        8'hC1, 8'h5D, 8'h8D, 8'h53, 8'h68, 8'hEC, 8'h6A, 8'h31,
        8'hC3, 8'h02, 8'hF0, 8'hD8, 8'hB8, 8'h56, 8'h73, 8'h03,
        8'h4D, 8'h7D, 8'h64, 8'h72, 8'hC4, 8'h50, 8'h14, 8'hE5,
        8'h80, 8'hAB, 8'h18, 8'h57, 8'h6F, 8'hF8, 8'h0A, 8'h61,
        8'h5E, 8'h43, 8'h39, 8'hD2, 8'hE9, 8'hB0, 8'h58, 8'hE0,
        8'h40, 8'h5F, 8'h70, 8'h6E, 8'h09, 8'h25, 8'h5B, 8'hE4,
        8'h15, 8'h84, 8'h06, 8'h6C, 8'h69, 8'hAA, 8'hC8, 8'hB6,
        8'hD0, 8'hFE, 8'h16, 8'h1C, 8'h07, 8'h63, 8'hC6, 8'h90,
        8'h24, 8'h81, 8'h3D, 8'h30, 8'h42, 8'hD3, 8'h5A, 8'h77,
        8'h46, 8'h76, 8'hBB, 8'hDC, 8'hC9, 8'h51, 8'hF7, 8'hFA,
        8'h52, 8'h78, 8'h29, 8'hF4, 8'h11, 8'h59, 8'h7F, 8'hF6,
        8'h0D, 8'h44, 8'h8A, 8'hB7, 8'h47, 8'h3B, 8'h3C, 8'hDB,
        8'h3A, 8'h7E, 8'h6D, 8'h41, 8'h88, 8'h35, 8'hCA, 8'hC2,
        8'h19, 8'hD4, 8'hBE, 8'h0B, 8'h4B, 8'h79, 8'h8F, 8'h38,
        8'h1E, 8'h21, 8'hBA, 8'hF9, 8'h7C, 8'h28, 8'h48, 8'h62,
        8'h2C, 8'h1F, 8'hA8, 8'h12, 8'h0E, 8'hE2, 8'hFC, 8'hEA,
        8'h8E, 8'hD1, 8'h60, 8'h17, 8'hFB, 8'hBC, 8'h6B, 8'h7B,
        8'h2B, 8'h13, 8'h1D, 8'hEE, 8'hA1, 8'h4E, 8'hCC, 8'h34,
        8'h4F, 8'hAE, 8'hA0, 8'h2E, 8'h67, 8'hAF, 8'hE3, 8'hA3,
        8'h22, 8'hD9, 8'hE1, 8'h4A, 8'h54, 8'hF3, 8'h23, 8'h33,
        8'hF2, 8'hDA, 8'hAC, 8'hCD, 8'hCF, 8'hD6, 8'h2F, 8'h99,
        8'h4C, 8'hB4, 8'h1A, 8'h8C, 8'hF1, 8'hD7, 8'h1B, 8'h3E,
        8'hCB, 8'hBF, 8'hB3, 8'h95, 8'hFD, 8'hB9, 8'hE6, 8'h2D,
        8'hA4, 8'hDE, 8'hCE, 8'h82, 8'hE7, 8'h86, 8'h5C, 8'h49,
        8'h37, 8'hB5, 8'h3F, 8'h92, 8'h26, 8'h71, 8'h9D, 8'h27,
        8'h32, 8'h36, 8'hEF, 8'hDF, 8'hA9, 8'h94, 8'hD5, 8'hB1,
        8'hED, 8'h87, 8'h98, 8'h2A, 8'h91, 8'hDD, 8'hBD, 8'h9C,
        8'h9E, 8'h7A, 8'h9A, 8'hF5, 8'h93, 8'h9F, 8'hB2, 8'hA5,
        8'h96, 8'hAD, 8'h97, 8'hA7, 8'hA2, 8'hC5, 8'h9B, 8'hA6
    };

    // inverse permutation, built at elaboration: byte -> rank
    function automatic rom_t build_rank_rom();
        rom_t r;
        for (int i = 0; i < 256; i++)
        begin
            r[PERM_ROM[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam rom_t RANK_ROM = build_rank_rom();

    // one queued job: up to four output bytes, first byte in slot 0
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            frame_done;
    } job_t;

endpackage

// File: rtl/length_prefixed_byte_compressor.sv
// ----------------------------------------------------------------------------
// length_prefixed_byte_compressor
// Frame compressor: 4-byte length header, then a fixed variable-length code.
// ----------------------------------------------------------------------------
// An item is taken in every cycle in which the job queue has room; its code
// is worked out in the same cycle and queued as a job of up to four bytes.
// The output side sends one byte per cycle while the receiver does not stall:
// a begin item gives four output bytes, a data item zero to three, so the
// sustained rate is set by the single output byte port (uniformly random data
// bytes average about 1.25 output bytes per data item). An item's first byte
// passes the queue store, the back's job register and its output register
// before it is offered. There is no clearing pass after reset.
module length_prefixed_byte_compressor
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [15:0] frame_length,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        run_end,
    output logic        frame_done
);

    logic           take;
    logic           push;
    lpbc_pkg::job_t push_job;
    lpbc_pkg::job_t head_job;
    logic           pop;
    logic           full;
    logic           empty;

    assign item_stall = full;
    assign take       = item_valid && !full;

    // front: coding and residue
    lpbc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .mode         (mode),
        .frame_length (frame_length),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .push         (push),
        .job          (push_job)
    );

    // job queue
    lpbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    // back: byte output
    lpbc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head_job   (head_job),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .frame_done (frame_done)
    );

endmodule

// File: rtl/lpbc_front.sv
// ----------------------------------------------------------------------------
// lpbc_front
// Accepts items, codes data bytes onto the bit residue and forms byte jobs.
// ----------------------------------------------------------------------------
module lpbc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                mode,
    input  logic [15:0]         frame_length,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                push,
    output lpbc_pkg::job_t      job
);

    logic [lpbc_pkg::RES_W-1:0]     residue_bits_reg;
    logic [lpbc_pkg::RES_W-1:0]     residue_bits_next;
    logic [lpbc_pkg::RES_CNT_W-1:0] residue_count_reg;
    logic [lpbc_pkg::RES_CNT_W-1:0] residue_count_next;

    logic [7:0]                     rank;
    logic [3:0]                     k;
    logic [lpbc_pkg::ACC_W-1:0]     acc;
    logic [lpbc_pkg::TOTAL_W-1:0]   total;
    logic [lpbc_pkg::ALIGN_W-1:0]   aligned;
    logic [2:0]                     rem;
    logic [1:0]                     n_full;
    logic                           pad;
    logic [1:0]                     n_bytes;
    logic [lpbc_pkg::RES_W-1:0]     rem_mask;

    // rank lookup and code length
    always_comb
    begin
        rank = lpbc_pkg::RANK_ROM[data_byte];
        if (rank[7])      k = 4'd8;
        else if (rank[6]) k = 4'd7;
        else if (rank[5]) k = 4'd6;
        else if (rank[4]) k = 4'd5;
        else if (rank[3]) k = 4'd4;
        else if (rank[2]) k = 4'd3;
        else if (rank[1]) k = 4'd2;
        else              k = 4'd1;
    end

    // append length field and rank to the residue, left-align the result
    always_comb
    begin
        acc = (lpbc_pkg::ACC_W'(residue_bits_reg) << (k + 4'd3))
            | (lpbc_pkg::ACC_W'(k - 4'd1) << k)
            | lpbc_pkg::ACC_W'(rank);
        total   = lpbc_pkg::TOTAL_W'(residue_count_reg) + lpbc_pkg::TOTAL_W'(k)
                + lpbc_pkg::TOTAL_W'(lpbc_pkg::LEN_FIELD_W);
        aligned = lpbc_pkg::ALIGN_W'(acc)
                << (lpbc_pkg::TOTAL_W'(lpbc_pkg::ALIGN_W) - total);
        n_full  = total[4:3];
        rem     = total[2:0];
        pad     = last_byte && (rem != 3'd0);
        n_bytes = n_full + {1'b0, pad};
        rem_mask = 7'h7F >> (3'd7 - rem);
    end

    // job and residue update per item kind
    always_comb
    begin
        job                = '0;
        push               = 1'b0;
        residue_bits_next  = residue_bits_reg;
        residue_count_next = residue_count_reg;
        if (take)
        begin
            if (mode == lpbc_pkg::MODE_BEGIN)
            begin
                push               = 1'b1;
                job.bytes[0]       = frame_length[7:0];
                job.bytes[1]       = frame_length[15:8];
                job.last_idx       = 2'(lpbc_pkg::HDR_LAST_IDX);
                job.frame_done     = (frame_length == 16'd0);
                residue_bits_next  = '0;
                residue_count_next = '0;
            end
            else
            begin
                push           = (n_bytes != 2'd0);
                job.bytes[0]   = aligned[23:16];
                job.bytes[1]   = aligned[15:8];
                job.bytes[2]   = aligned[7:0];
                job.last_idx   = n_bytes - 2'd1;
                job.frame_done = last_byte;
                if (last_byte)
                begin
                    residue_bits_next  = '0;
                    residue_count_next = '0;
                end
                else
                begin
                    residue_bits_next  = acc[lpbc_pkg::RES_W-1:0] & rem_mask;
                    residue_count_next = rem;
                end
            end
        end
    end

    // residue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_bits_reg  <= '0;
            residue_count_reg <= '0;
        end
        else
        begin
            residue_bits_reg  <= residue_bits_next;
            residue_count_reg <= residue_count_next;
        end
    end

endmodule

// File: rtl/lpbc_queue.sv
// ----------------------------------------------------------------------------
// lpbc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lpbc_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lpbc_pkg::job_t push_job,
    input  logic           pop,
    output lpbc_pkg::job_t head_job,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpbc_pkg::job_t   store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = store_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/lpbc_back.sv
// ----------------------------------------------------------------------------
// lpbc_back
// Takes jobs from the queue and sends their bytes out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module lpbc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  lpbc_pkg::job_t head_job,
    output logic           pop,
    output logic           byte_valid,
    input  logic           byte_stall,
    output logic [7:0]     out_byte,
    output logic           run_end,
    output logic           frame_done
);

    logic           job_valid_reg;
    logic           job_valid_next;
    lpbc_pkg::job_t job_reg;
    logic [1:0]     idx_reg;
    logic [1:0]     idx_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_byte_reg;
    logic           run_end_reg;
    logic           frame_done_reg;

    logic           advance;
    logic           at_last;
    logic           job_finish;

    assign advance    = !out_valid_reg || !byte_stall;
    assign at_last    = (idx_reg == job_reg.last_idx);
    assign job_finish = job_valid_reg && advance && at_last;
    assign pop        = (!job_valid_reg || job_finish) && !empty;

    // current job and byte index
    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (job_valid_reg && advance)
        begin
            idx_next = idx_reg + 2'd1;
        end
        if (job_finish)
        begin
            job_valid_next = 1'b0;
            idx_next       = 2'd0;
        end
        if (pop)
        begin
            job_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        if (advance)
        begin
            out_valid_next = job_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job payload and output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
        if (advance && job_valid_reg)
        begin
            out_byte_reg   <= job_reg.bytes[idx_reg];
            run_end_reg    <= at_last;
            frame_done_reg <= at_last && job_reg.frame_done;
        end
    end

    assign byte_valid = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_end    = run_end_reg;
    assign frame_done = frame_done_reg;

endmodule

// File: rtl/lpbc_checker.sv
// ----------------------------------------------------------------------------
// lpbc_checker
// Port-level checks of the compressor output stream.
// ----------------------------------------------------------------------------
module lpbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  out_byte,
    input logic        run_end,
    input logic        frame_done
);

    // a stalled byte stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid)
        else $error("output byte dropped while stalled");

    // a stalled byte keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=>
            $stable(out_byte) && $stable(run_end) && $stable(frame_done))
        else $error("output payload changed while stalled");

    // the frame ends only on the last byte of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && frame_done |-> run_end)
        else $error("frame_done without run_end");

    // bytes of one item leave back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && !run_end |=> byte_valid)
        else $error("gap inside the bytes of one item");

    // right after reset nothing is offered on the output
    assert property (@(posedge clk)
        !rst_n |=> !byte_valid)
        else $error("output valid straight after reset");

endmodule

bind length_prefixed_byte_compressor lpbc_checker u_lpbc_checker (.*);

// File: verif/tb_length_prefixed_byte_compressor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_byte_compressor
// Self-checking bench for the length-prefixed byte compressor.
// ----------------------------------------------------------------------------
// Begin and data items go in through a sender task. Each accepted item is run
// through a bit-level model of the header and the variable-length code, and
// the model queues the bytes that the item should produce. A monitor pops one
// queued byte per accepted output byte and compares value, run_end and
// frame_done. Both sides idle at random, and one stretch runs with no idling.
// ----------------------------------------------------------------------------
module tb_length_prefixed_byte_compressor;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 8;
    localparam int MAX_REPORTS  = 10;

    // one byte of the compressed stream as the block should send it
    typedef struct {
        logic [7:0] value;
        logic       run_end;
        logic       frame_done;
    } code_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        mode = lpbc_pkg::MODE_BEGIN;
    logic [15:0] frame_length = 16'h0000;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        frame_done;

    // model state: code bits still waiting to fill a byte
    logic [6:0]  pend_bits = '0;
    logic [2:0]  pend_count = '0;
    code_byte_t  expected_bytes[$];

    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          begins_sent = 0;
    int          data_sent = 0;
    int          bytes_checked = 0;
    int          frames_closed = 0;

    length_prefixed_byte_compressor dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .frame_length (frame_length),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .out_byte     (out_byte),
        .run_end      (run_end),
        .frame_done   (frame_done)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
                     expected_bytes.size());
            $display("length_prefixed_byte_compressor test failed");
            $finish;
        end
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        int hold;
        if (!stalls_on)
        begin
            byte_stall <= 1'b0;
            hold = 0;
        end
        else if (hold > 0)
        begin
            hold--;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            byte_stall <= 1'b1;
            hold = pick_gap() - 1;
        end
        else
        begin
            byte_stall <= 1'b0;
            hold = $urandom_range(0, 4);
        end
    end

    // rank of a byte: its index in the permutation table
    function automatic logic [7:0] code_rank(logic [7:0] b);
        for (int i = 255; i >= 0; i--)
        begin
            if (lpbc_pkg::PERM_ROM[i] == b)
                return 8'(i);
        end
        return 8'h00;
    endfunction

    function automatic code_byte_t make_byte(logic [7:0] v, logic e, logic d);
        code_byte_t cb;
        cb.value = v;
        cb.run_end = e;
        cb.frame_done = d;
        return cb;
    endfunction

    // header and code bytes caused by one accepted item
    task automatic compress_item(logic m, logic [15:0] len, logic [7:0] d, logic fin);
        logic [7:0]  rank;
        logic [17:0] acc;
        logic [7:0]  ready[3];
        int          k;
        int          total;
        int          n;
        if (m == lpbc_pkg::MODE_BEGIN)
        begin
            pend_bits = '0;
            pend_count = '0;
            expected_bytes.push_back(make_byte(len[7:0], 1'b0, 1'b0));
            expected_bytes.push_back(make_byte(len[15:8], 1'b0, 1'b0));
            expected_bytes.push_back(make_byte(8'h00, 1'b0, 1'b0));
            expected_bytes.push_back(make_byte(8'h00, 1'b1, len == 16'h0000));
        end
        else
        begin
            rank = code_rank(d);
            k = 1;
            while (k < 8 && (rank >> k) != 0)
                k++;
            // pending bits, then the 3-bit length field, then the rank
            acc = (18'(pend_bits) << (3 + k)) | (18'(k - 1) << k) | 18'(rank);
            total = int'(pend_count) + 3 + k;
            n = 0;
            while (total >= 8)
            begin
                ready[n] = 8'(acc >> (total - 8));
                n++;
                total -= 8;
            end
            acc &= (18'(1) << total) - 18'(1);
            // zero pad on the last byte of a frame
            if (fin && total != 0)
            begin
                ready[n] = 8'(acc << (8 - total));
                n++;
                total = 0;
                acc = '0;
            end
            pend_bits = 7'(acc);
            pend_count = 3'(total);
            for (int i = 0; i < n; i++)
                expected_bytes.push_back(make_byte(ready[i], i == n - 1, (i == n - 1) && fin));
        end
    endtask

    // output monitor and checker
    always @(posedge clk)
    begin
        code_byte_t want;
        if (rst_n && byte_valid && !byte_stall)
        begin
            bytes_checked++;
            if (frame_done)
                frames_closed++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected byte %02h end %0b done %0b", out_byte,
                             run_end, frame_done);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value || run_end !== want.run_end ||
                    frame_done !== want.frame_done)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"ERROR: byte %0d expected %02h end %0b done %0b, ",
                                  "got %02h end %0b done %0b"},
                                 bytes_checked, want.value, want.run_end, want.frame_done,
                                 out_byte, run_end, frame_done);
                end
            end
        end
    end

    // send one item, wait for its acceptance, then maybe idle
    task automatic send_item(logic m, logic [15:0] len, logic [7:0] d, logic fin);
        int gap;
        item_valid <= 1'b1;
        mode <= m;
        frame_length <= len;
        data_byte <= d;
        last_byte <= fin;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        compress_item(m, len, d, fin);
        if (m == lpbc_pkg::MODE_BEGIN)
            begins_sent++;
        else
            data_sent++;
        if (gaps_on && $urandom_range(0, 99) < 40)
        begin
            gap = pick_gap();
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every due byte is out
    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // data byte with a code of the given rank
    function automatic logic [7:0] byte_of_rank(int r);
        return lpbc_pkg::PERM_ROM[r];
    endfunction

    // header bytes at the length extremes, empty frame included
    task automatic test_header_extremes();
        send_item(lpbc_pkg::MODE_BEGIN, 16'h0000, 8'h00, 1'b0);
        send_item(lpbc_pkg::MODE_BEGIN, 16'hFFFF, 8'hFF, 1'b1);
        send_item(lpbc_pkg::MODE_BEGIN, 16'h5AA5, 8'h00, 1'b0);
        send_item(lpbc_pkg::MODE_BEGIN, 16'hA55A, 8'h00, 1'b0);
        send_item(lpbc_pkg::MODE_BEGIN, 16'h0001, 8'h00, 1'b0);
    endtask

    // data bytes covering every code length, 1 to 8 rank bits
    task automatic test_code_lengths();
        int ranks[9] = '{0, 1, 3, 7, 15, 31, 63, 127, 255};
        send_item(lpbc_pkg::MODE_BEGIN, 16'd9, 8'h00, 1'b0);
        foreach (ranks[i])
            send_item(lpbc_pkg::MODE_DATA, 16'h0000, byte_of_rank(ranks[i]), i == 8);
    endtask

    // exact fit on last, data with no begin, begin dropping bits, pad flush
    task automatic test_special_cases();
        send_item(lpbc_pkg::MODE_BEGIN, 16'd1, 8'h00, 1'b0);
        send_item(lpbc_pkg::MODE_DATA, 16'hFFFF, byte_of_rank(16), 1'b1);
        send_item(lpbc_pkg::MODE_DATA, 16'h0000, byte_of_rank(0), 1'b0);
        send_item(lpbc_pkg::MODE_BEGIN, 16'd3, 8'h00, 1'b0);
        send_item(lpbc_pkg::MODE_DATA, 16'h0000, byte_of_rank(1), 1'b0);
        send_item(lpbc_pkg::MODE_DATA, 16'h0000, byte_of_rank(2), 1'b0);
        send_item(lpbc_pkg::MODE_DATA, 16'h0000, byte_of_rank(0), 1'b1);
    endtask

    // mostly well-formed frames with random content, some noise
    task automatic run_frames(int item_count, bit pause_midway);
        int start;
        int n;
        bit paused;
        logic [7:0] d;
        start = begins_sent + data_sent;
        paused = 1'b0;
        while (begins_sent + data_sent - start < item_count)
        begin
            if (pause_midway && !paused && begins_sent + data_sent - start >= item_count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
                if ($urandom_range(0, 9) == 0)
                    send_item(lpbc_pkg::MODE_BEGIN, 16'($urandom), 8'($urandom),
                              1'($urandom));
                else
                    send_item(lpbc_pkg::MODE_BEGIN, 16'(n), 8'($urandom), 1'b0);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 1) == 1)
                        d = 8'($urandom);
                    else
                        d = byte_of_rank($urandom_range(0, 15));
                    send_item(lpbc_pkg::MODE_DATA, 16'($urandom), d, i == n - 1);
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_item(1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        run_frames(200, 1'b1);
        drain_results();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        run_frames(90, 1'b0);
        drain_results();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_extremes();
        test_code_lengths();
        test_special_cases();
        drain_results();
        test_random_traffic();
        test_back_to_back();
        $display("sent %0d begin items and %0d data items, checked %0d bytes",
                 begins_sent, data_sent, bytes_checked);
        $display("%0d frames closed with frame_done, %0d mismatches", frames_closed,
                 mismatches);
        if (mismatches == 0)
            $display("length_prefixed_byte_compressor test passed");
        else
            $display("length_prefixed_byte_compressor test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/lpbc_pkg.sv
rtl/lpbc_front.sv
rtl/lpbc_queue.sv
rtl/lpbc_back.sv
rtl/length_prefixed_byte_compressor.sv
rtl/lpbc_checker.sv
verif/tb_length_prefixed_byte_compressor.sv
